// File: rtl/mi3_pkg.sv
// shared constants and cofactor index tables for the 3x3 inverse pipeline
`timescale 1ns / 1ps

package mi3_pkg;

  // fixed result widths
  localparam int OUT_W = 32;
  localparam int DET_W = 50;

  // quotient bits produced by each divider lane
  localparam int QB = 32;

  // divider lane latency: magnitude stage, range check, one stage per bit, saturation
  localparam int DIV_LAT = QB + 3;

  localparam logic [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};

  // adjugate entry k = m[MA[k]] * m[MD[k]] - m[MB[k]] * m[MC[k]]
  localparam int MA [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int MB [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int MC [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};
  localparam int MD [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};

endpackage

// File: rtl/mi3_adj.sv
// front end: 2x2 minors, signed adjugate and exact determinant in five stages
`timescale 1ns / 1ps

module mi3_adj import mi3_pkg::*; #(
  parameter int EW = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [8:0][EW-1:0]        m_in,
  output logic                      out_valid,
  output logic [8:0][EW-1:0]        m_out,
  output logic [8:0][2*EW:0]        adj_out,
  output logic [3*EW+2:0]           det_out
);

  localparam int PW = 2 * EW;
  localparam int AW = 2 * EW + 1;
  localparam int TW = EW + AW;
  localparam int DW = 3 * EW + 3;

  logic [4:0]                 v_r;
  logic [8:0][EW-1:0]         m1_r, m2_r, m3_r, m4_r, m5_r;
  logic signed [PW-1:0]       pad_r [9];
  logic signed [PW-1:0]       pbc_r [9];
  logic [8:0][AW-1:0]         adj3_r, adj4_r, adj5_r;
  logic signed [TW-1:0]       pd_r [3];
  logic signed [DW-1:0]       det5_r;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  // stage 1 input capture, stage 2 minor products
  always_ff @(posedge clk) begin
    m1_r <= m_in;
    m2_r <= m1_r;
    for (int k = 0; k < 9; k++) begin
      pad_r[k] <= PW'($signed(m1_r[MA[k]])) * PW'($signed(m1_r[MD[k]]));
      pbc_r[k] <= PW'($signed(m1_r[MB[k]])) * PW'($signed(m1_r[MC[k]]));
    end
  end

  // stage 3 minors, stage 4 determinant products
  always_ff @(posedge clk) begin
    m3_r <= m2_r;
    for (int k = 0; k < 9; k++) begin
      adj3_r[k] <= AW'(pad_r[k]) - AW'(pbc_r[k]);
    end
    m4_r   <= m3_r;
    adj4_r <= adj3_r;
    for (int j = 0; j < 3; j++) begin
      pd_r[j] <= TW'($signed(m3_r[j])) * TW'($signed(adj3_r[3*j]));
    end
  end

  // stage 5 determinant sum
  always_ff @(posedge clk) begin
    m5_r   <= m4_r;
    adj5_r <= adj4_r;
    det5_r <= DW'(pd_r[0]) + DW'(pd_r[1]) + DW'(pd_r[2]);
  end

  assign out_valid = v_r[4];
  assign m_out     = m5_r;
  assign adj_out   = adj5_r;
  assign det_out   = det5_r;

endmodule

// File: rtl/mi3_div.sv
// one divider lane: trunc(adj * 2^SH / det) saturated to 32 bits, one quotient bit a stage
`timescale 1ns / 1ps

module mi3_div import mi3_pkg::*; #(
  parameter int AW = 33,
  parameter int DW = 51,
  parameter int SH = 24
) (
  input  logic              clk,
  input  logic [AW-1:0]     adj,
  input  logic [DW-1:0]     det,
  output logic [OUT_W-1:0]  quo
);

  localparam int XW = (AW + SH > DW + QB) ? AW + SH : DW + QB;

  logic [AW-1:0]    ua_r;
  logic [DW-1:0]    ud_r;
  logic             nega_r;
  logic [XW-1:0]    nx, dx;

  logic [DW-1:0]    rem_r [QB];
  logic [DW-1:0]    d_r   [QB];
  logic [QB-1:0]    nl_r  [QB];
  logic [QB-1:0]    q_r   [QB+1];
  logic             neg_r [QB+1];
  logic             ovf_r [QB+1];
  logic [OUT_W-1:0] quo_r;

  // magnitudes and result sign
  always_ff @(posedge clk) begin
    ua_r   <= adj[AW-1] ? AW'(-$signed(adj)) : adj;
    ud_r   <= det[DW-1] ? DW'(-$signed(det)) : det;
    nega_r <= adj[AW-1] ^ det[DW-1];
  end

  // range check: quotient of 2^32 or more saturates
  assign nx = XW'(ua_r) << SH;
  assign dx = XW'(ud_r) << QB;

  always_ff @(posedge clk) begin
    rem_r[0] <= DW'(nx >> QB);
    nl_r[0]  <= nx[QB-1:0];
    d_r[0]   <= ud_r;
    q_r[0]   <= '0;
    neg_r[0] <= nega_r;
    ovf_r[0] <= (nx >= dx);
  end

  // restoring division, one bit per stage
  for (genvar i = 0; i < QB; i++) begin : g_step
    logic [DW:0] t;
    logic        ge;

    assign t  = {rem_r[i], nl_r[i][QB-1-i]};
    assign ge = (t >= {1'b0, d_r[i]});

    always_ff @(posedge clk) begin
      q_r[i+1]   <= {q_r[i][QB-2:0], ge};
      neg_r[i+1] <= neg_r[i];
      ovf_r[i+1] <= ovf_r[i];
    end

    // remainder, divisor and dividend bits go on until the last stage
    if (i < QB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[i+1] <= ge ? DW'(t - {1'b0, d_r[i]}) : DW'(t);
        nl_r[i+1]  <= nl_r[i];
        d_r[i+1]   <= d_r[i];
      end
    end
  end

  // sign and saturation
  always_ff @(posedge clk) begin
    if (ovf_r[QB]) begin
      quo_r <= neg_r[QB] ? SAT_NEG : SAT_POS;
    end else if (neg_r[QB]) begin
      quo_r <= q_r[QB][QB-1] ? SAT_NEG : OUT_W'(-q_r[QB]);
    end else begin
      quo_r <= q_r[QB][QB-1] ? SAT_POS : OUT_W'(q_r[QB]);
    end
  end

  assign quo = quo_r;

endmodule

// File: rtl/matrix3x3_inverse_unit.sv
// top level: 3x3 matrix inverse by adjugate over determinant, fully pipelined
`timescale 1ns / 1ps
//
// a matrix of nine signed elements (ELEM_WIDTH bits, FRAC_BITS fraction bits) is
// taken as an item at each rising edge with start high and busy low. busy stays
// low: the pipeline advances every cycle, so one item enters per clock.
// each item gives one result: out_valid is high for one cycle with the nine
// inverse elements (Q16.16, saturated), the exact determinant and the singular
// flag. the divider lanes make one quotient bit per stage (32 stages) after a
// five-stage adjugate front end. throughput is one item per cycle; the receiver
// cannot stall and results are never held back.
// a zero determinant sets singular and returns the input scaled to Q16.16.
// synchronous reset clears the valid bits only; no result appears until an
// item has passed the whole pipeline.
//
module matrix3x3_inverse_unit import mi3_pkg::*; #(
  parameter int ELEM_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [ELEM_WIDTH-1:0] in_m00,
  input  logic signed [ELEM_WIDTH-1:0] in_m01,
  input  logic signed [ELEM_WIDTH-1:0] in_m02,
  input  logic signed [ELEM_WIDTH-1:0] in_m10,
  input  logic signed [ELEM_WIDTH-1:0] in_m11,
  input  logic signed [ELEM_WIDTH-1:0] in_m12,
  input  logic signed [ELEM_WIDTH-1:0] in_m20,
  input  logic signed [ELEM_WIDTH-1:0] in_m21,
  input  logic signed [ELEM_WIDTH-1:0] in_m22,
  output logic                         out_valid,
  output logic signed [OUT_W-1:0]      out_r00,
  output logic signed [OUT_W-1:0]      out_r01,
  output logic signed [OUT_W-1:0]      out_r02,
  output logic signed [OUT_W-1:0]      out_r10,
  output logic signed [OUT_W-1:0]      out_r11,
  output logic signed [OUT_W-1:0]      out_r12,
  output logic signed [OUT_W-1:0]      out_r20,
  output logic signed [OUT_W-1:0]      out_r21,
  output logic signed [OUT_W-1:0]      out_r22,
  output logic signed [DET_W-1:0]      out_determinant,
  output logic                         out_singular
);

  localparam int EW = ELEM_WIDTH;
  localparam int AW = 2 * EW + 1;
  localparam int DW = 3 * EW + 3;
  localparam int SH = 3 * FRAC_BITS;

  logic [8:0][EW-1:0]  m_in;
  logic                fe_valid;
  logic [8:0][EW-1:0]  fe_m;
  logic [8:0][AW-1:0]  fe_adj;
  logic [DW-1:0]       fe_det;
  logic [OUT_W-1:0]    quo [9];

  logic [DIV_LAT-1:0]  vdl_r;
  logic [8:0][EW-1:0]  mdl_r [DIV_LAT];
  logic [DW-1:0]       ddl_r [DIV_LAT];
  logic                sdl_r [DIV_LAT];

  logic                out_valid_r;
  logic [OUT_W-1:0]    res_r [9];
  logic [DET_W-1:0]    det_r;
  logic                sing_r;

  // never stalls
  assign busy = 1'b0;

  assign m_in = {in_m22, in_m21, in_m20, in_m12, in_m11, in_m10, in_m02, in_m01, in_m00};

  // adjugate and determinant
  mi3_adj #(.EW(EW)) u_adj (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start & ~busy),
    .m_in      (m_in),
    .out_valid (fe_valid),
    .m_out     (fe_m),
    .adj_out   (fe_adj),
    .det_out   (fe_det)
  );

  // nine divider lanes
  for (genvar k = 0; k < 9; k++) begin : g_lane
    mi3_div #(.AW(AW), .DW(DW), .SH(SH)) u_div (
      .clk (clk),
      .adj (fe_adj[k]),
      .det (fe_det),
      .quo (quo[k])
    );
  end

  // valid bits alongside the divider lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vdl_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vdl_r       <= {vdl_r[DIV_LAT-2:0], fe_valid};
      out_valid_r <= vdl_r[DIV_LAT-1];
    end
  end

  // matrix, determinant and singular flag delayed to match the lanes
  always_ff @(posedge clk) begin
    mdl_r[0] <= fe_m;
    ddl_r[0] <= fe_det;
    sdl_r[0] <= (fe_det == '0);
    for (int i = 1; i < DIV_LAT; i++) begin
      mdl_r[i] <= mdl_r[i-1];
      ddl_r[i] <= ddl_r[i-1];
      sdl_r[i] <= sdl_r[i-1];
    end
  end

  // output register: quotient or scaled input
  always_ff @(posedge clk) begin
    sing_r <= sdl_r[DIV_LAT-1];
    det_r  <= DET_W'($signed(ddl_r[DIV_LAT-1]));
    for (int k = 0; k < 9; k++) begin
      res_r[k] <= sdl_r[DIV_LAT-1] ?
                  (OUT_W'($signed(mdl_r[DIV_LAT-1][k])) << FRAC_BITS) : quo[k];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_r00         = res_r[0];
  assign out_r01         = res_r[1];
  assign out_r02         = res_r[2];
  assign out_r10         = res_r[3];
  assign out_r11         = res_r[4];
  assign out_r12         = res_r[5];
  assign out_r20         = res_r[6];
  assign out_r21         = res_r[7];
  assign out_r22         = res_r[8];
  assign out_determinant = det_r;
  assign out_singular    = sing_r;

endmodule
